>>> sv/cbor_hkdf_pkg.sv
`default_nettype none
package cbor_hkdf_pkg;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ID      = 2'd1,
      PH_CONTEXT = 2'd2,
      PH_TYPE    = 2'd3
   } phase_type;

   localparam logic OP_BEGIN   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   localparam logic [1:0] REG_CAPACITY = 2'd0;
   localparam logic [1:0] REG_ALG_ID   = 2'd1;

   localparam logic [7:0] CBOR_ARRAY5    = 8'h85;
   localparam logic [7:0] CBOR_BSTR      = 8'h40;
   localparam logic [7:0] CBOR_BSTR_U8   = 8'h58;
   localparam logic [7:0] CBOR_NULL      = 8'hf6;
   localparam logic [7:0] CBOR_TSTR      = 8'h60;
   localparam logic [7:0] CBOR_UINT_U8   = 8'h18;
   localparam logic [7:0] CBOR_INLINE_MAX = 8'd23;
   localparam logic [9:0] KEY_MAX        = 10'd255;

   localparam logic [9:0] CAPACITY_RESET = 10'd1023;
   localparam logic [4:0] ALG_ID_RESET   = 5'd10;

   localparam int MAX_RESULTS = 7;
   localparam int QUEUE_DEPTH = 8;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       error;
      logic [9:0] total_length;
   } rsp_entry_type;

endpackage
`default_nettype wire

>>> sv/cbor_hkdf_req_if.sv
`default_nettype none
interface cbor_hkdf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] id_length;
   logic [7:0] context_length;
   logic [7:0] type_length;
   logic [9:0] key_length;
   logic [7:0] data_byte;

   modport source (
      output valid, op, id_length, context_length, type_length, key_length, data_byte,
      input  ready
   );
   modport sink (
      input  valid, op, id_length, context_length, type_length, key_length, data_byte,
      output ready
   );
endinterface
`default_nettype wire

>>> sv/cbor_hkdf_rsp_if.sv
`default_nettype none
interface cbor_hkdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;
   logic       error;
   logic [9:0] total_length;

   modport source (
      output valid, out_byte, last_byte, error, total_length,
      input  ready
   );
   modport sink (
      input  valid, out_byte, last_byte, error, total_length,
      output ready
   );
endinterface
`default_nettype wire

>>> sv/cbor_hkdf_info_encoder_unit.sv
`default_nettype none
// channel       | dir | handshake              | payload
// req_channel   | in  | valid/ready            | op, lengths, data_byte
// rsp_channel   | out | valid/ready            | out_byte, last_byte, error, total_length
// csr_*         | in  | apb write, pready high | capacity @0x0, alg_id @0x4
//
// a request is decoded in the cycle it is accepted into up to seven result bytes
// that go into an eight-entry result queue; while rsp_channel.ready is high one
// result leaves per cycle; req_channel.ready is high while the queue holds at
// most one result, so with rsp_channel.ready high, single-result payload requests
// stream at one per cycle and a multi-byte header burst holds the next request while the queue drains
// synchronous reset empties the queue and returns the encoder to idle
module cbor_hkdf_info_encoder_unit
   import cbor_hkdf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   cbor_hkdf_req_if.sink    req_channel,
   cbor_hkdf_rsp_if.source  rsp_channel,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [9:0] capacity_ff;
   logic [4:0] alg_id_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] ctx_len_ff, ctx_len_in;
   logic [4:0] tstr_len_ff, tstr_len_in;
   logic [7:0] key_len_ff, key_len_in;
   logic [9:0] byte_count_ff, byte_count_in;

   rsp_entry_type queue_ff [QUEUE_DEPTH];
   rsp_entry_type queue_in [QUEUE_DEPTH];
   logic [3:0]    count_ff, count_in;

   rsp_entry_type entries [MAX_RESULTS];
   logic [3:0]    num_results;
   logic          begin_error;
   logic [9:0]    bc_base;
   logic [9:0]    total_size;
   logic          do_ctx, do_tail, do_key;

   logic req_accept;
   logic rsp_pop;
   logic csr_write;
   logic [3:0] base;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         alg_id_ff   <= ALG_ID_RESET;
      end else if (csr_write) begin
         unique case ({1'b0, csr_paddr[2]})
            REG_CAPACITY: capacity_ff <= csr_pwdata[9:0];
            REG_ALG_ID:   alg_id_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case ({1'b0, csr_paddr[2]})
         REG_CAPACITY: csr_prdata = {22'd0, capacity_ff};
         REG_ALG_ID:   csr_prdata = {27'd0, alg_id_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // size check for a begin request
   always_comb begin
      total_size = 10'd3 + {2'd0, req_channel.id_length}
                 + ((req_channel.id_length <= CBOR_INLINE_MAX) ? 10'd1 : 10'd2)
                 + {2'd0, req_channel.type_length}
                 + ((req_channel.key_length <= 10'(CBOR_INLINE_MAX)) ? 10'd1 : 10'd2);
      if (req_channel.context_length == 8'd0) begin
         total_size = total_size + 10'd1;
      end else begin
         total_size = total_size + {2'd0, req_channel.context_length}
                    + ((req_channel.context_length <= CBOR_INLINE_MAX) ? 10'd1 : 10'd2);
      end
      begin_error = (req_channel.type_length > CBOR_INLINE_MAX)
                  || (req_channel.key_length > KEY_MAX)
                  || (total_size > capacity_ff);
   end

   // result generation and next state for one request
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      ctx_len_in   = ctx_len_ff;
      tstr_len_in  = tstr_len_ff;
      key_len_in   = key_len_ff;
      bc_base      = byte_count_ff;
      num_results  = '0;
      do_ctx       = 1'b0;
      do_tail      = 1'b0;
      do_key       = 1'b0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         entries[k] = '0;
      end

      if (req_channel.op == OP_BEGIN) begin
         phase_in     = PH_IDLE;
         remaining_in = '0;
         bc_base      = '0;
         if (begin_error) begin
            entries[0]  = '{out_byte: 8'd0, last_byte: 1'b1, error: 1'b1, total_length: 10'd0};
            num_results = 4'd1;
         end else begin
            ctx_len_in  = req_channel.context_length;
            tstr_len_in = req_channel.type_length[4:0];
            key_len_in  = req_channel.key_length[7:0];
            entries[num_results[2:0]].out_byte = CBOR_ARRAY5;
            num_results = num_results + 4'd1;
            if (req_channel.id_length <= CBOR_INLINE_MAX) begin
               entries[num_results[2:0]].out_byte = CBOR_BSTR | req_channel.id_length;
               num_results = num_results + 4'd1;
            end else begin
               entries[num_results[2:0]].out_byte = CBOR_BSTR_U8;
               num_results = num_results + 4'd1;
               entries[num_results[2:0]].out_byte = req_channel.id_length;
               num_results = num_results + 4'd1;
            end
            if (req_channel.id_length == 8'd0) begin
               do_ctx = 1'b1;
            end else begin
               phase_in     = PH_ID;
               remaining_in = req_channel.id_length;
            end
         end
      end else if (phase_ff != PH_IDLE && remaining_ff != 8'd0) begin
         entries[num_results[2:0]].out_byte = req_channel.data_byte;
         num_results  = num_results + 4'd1;
         remaining_in = remaining_ff - 8'd1;
         if (remaining_in == 8'd0) begin
            case (phase_ff)
               PH_ID:      do_ctx  = 1'b1;
               PH_CONTEXT: do_tail = 1'b1;
               default:    do_key  = 1'b1;
            endcase
         end
      end

      if (do_ctx) begin
         if (ctx_len_in == 8'd0) begin
            entries[num_results[2:0]].out_byte = CBOR_NULL;
            num_results = num_results + 4'd1;
            do_tail = 1'b1;
         end else begin
            if (ctx_len_in <= CBOR_INLINE_MAX) begin
               entries[num_results[2:0]].out_byte = CBOR_BSTR | ctx_len_in;
               num_results = num_results + 4'd1;
            end else begin
               entries[num_results[2:0]].out_byte = CBOR_BSTR_U8;
               num_results = num_results + 4'd1;
               entries[num_results[2:0]].out_byte = ctx_len_in;
               num_results = num_results + 4'd1;
            end
            phase_in     = PH_CONTEXT;
            remaining_in = ctx_len_in;
         end
      end

      if (do_tail) begin
         entries[num_results[2:0]].out_byte = {3'd0, alg_id_ff};
         num_results = num_results + 4'd1;
         entries[num_results[2:0]].out_byte = CBOR_TSTR | {3'd0, tstr_len_in};
         num_results = num_results + 4'd1;
         if (tstr_len_in == 5'd0) begin
            do_key = 1'b1;
         end else begin
            phase_in     = PH_TYPE;
            remaining_in = {3'd0, tstr_len_in};
         end
      end

      if (do_key) begin
         if (key_len_in > CBOR_INLINE_MAX) begin
            entries[num_results[2:0]].out_byte = CBOR_UINT_U8;
            num_results = num_results + 4'd1;
         end
         entries[num_results[2:0]].out_byte     = key_len_in;
         entries[num_results[2:0]].last_byte    = 1'b1;
         entries[num_results[2:0]].total_length = bc_base + {6'd0, num_results} + 10'd1;
         num_results  = num_results + 4'd1;
         phase_in     = PH_IDLE;
         remaining_in = '0;
      end

      if (req_channel.op == OP_BEGIN && begin_error) begin
         byte_count_in = '0;
      end else begin
         byte_count_in = bc_base + {6'd0, num_results};
      end
   end

   // result queue
   assign req_channel.ready = (count_ff <= 4'd1);
   assign req_accept        = req_channel.valid & req_channel.ready;
   assign rsp_channel.valid = (count_ff != 4'd0);
   assign rsp_pop           = rsp_channel.valid & rsp_channel.ready;
   assign base              = count_ff - {3'd0, rsp_pop};

   assign rsp_channel.out_byte     = queue_ff[0].out_byte;
   assign rsp_channel.last_byte    = queue_ff[0].last_byte;
   assign rsp_channel.error        = queue_ff[0].error;
   assign rsp_channel.total_length = queue_ff[0].total_length;

   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         queue_in[j] = queue_ff[j];
      end
      if (rsp_pop) begin
         for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            queue_in[j] = queue_ff[j + 1];
         end
      end
      if (req_accept) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (4'(k) < num_results) begin
               queue_in[3'(base[2:0] + 3'(k))] = entries[k];
            end
         end
      end
      count_in = base + (req_accept ? num_results : 4'd0);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         queue_ff[j] <= queue_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         phase_ff      <= PH_IDLE;
         remaining_ff  <= '0;
         ctx_len_ff    <= '0;
         tstr_len_ff   <= '0;
         key_len_ff    <= '0;
         byte_count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            phase_ff      <= phase_in;
            remaining_ff  <= remaining_in;
            ctx_len_ff    <= ctx_len_in;
            tstr_len_ff   <= tstr_len_in;
            key_len_ff    <= key_len_in;
            byte_count_ff <= byte_count_in;
         end
      end
   end

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_segment_open: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> remaining_ff != 8'd0)
      else $error("open segment with nothing remaining");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.error |->
         rsp_channel.last_byte && rsp_channel.out_byte == 8'd0
         && rsp_channel.total_length == 10'd0)
      else $error("malformed error result");

   a_bad_begin_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_channel.op == OP_BEGIN && begin_error |=>
         phase_ff == PH_IDLE && byte_count_ff == 10'd0)
      else $error("encoder not idle after rejected begin");

endmodule
`default_nettype wire
